[sv/gawu_pkg.sv]
// gawu_pkg: types and constants shared by the watchpoint unit modules
// no dependencies
`default_nettype none
package gawu_pkg;

  typedef enum logic [2:0] {
    OP_ARM_RANGE  = 3'd0,
    OP_ARM_VALUE  = 3'd1,
    OP_READ       = 3'd2,
    OP_READ_NOW   = 3'd3,
    OP_WRITE      = 3'd4,
    OP_BULK       = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_MMIO    = 3'd2,
    ST_ARMED   = 3'd3,
    ST_DUP     = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_MEM_SIZE    = 2'd0,
    REG_WATCH_PAGE  = 2'd1,
    REG_MMIO_ENABLE = 2'd2
  } reg_e;

  localparam int unsigned CfgDataW    = 33;
  localparam logic [31:0] GuardLimit  = 32'h0000_1000;
  localparam logic [31:0] MmioBase    = 32'h7FC8_0000;
  localparam logic [31:0] MmioMask    = 32'hFFFF_0000;
  localparam logic [19:0] WatchReset  = 20'h50000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] address;
    logic [31:0] range_end;
    logic [31:0] size;
    logic [63:0] data;
    logic [31:0] last_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        report_valid;
    logic        report_write;
    logic [31:0] report_address;
    logic [31:0] report_value;
    logic        last;
  } out_item_t;

  // classified work passed from front to back
  typedef struct packed {
    logic        hit;      // watch hit found, reports go out
    logic        two;      // two reports
    logic        write;
    logic [2:0]  status;
    logic [31:0] addr0;
    logic [31:0] val0;
    logic [31:0] addr1;
    logic [31:0] val1;
  } job_t;

endpackage
`default_nettype wire

[sv/gawu_front.sv]
// gawu_front: holds the watch tables and classifies each incoming beat
// depends on gawu_pkg
`default_nettype none
module gawu_front #(
  parameter int unsigned RANGE_ENTRIES = 64,
  parameter int unsigned VALUE_ENTRIES = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       take_i,
  input  wire gawu_pkg::in_item_t         item_i,
  input  wire logic [32:0]                mem_size_i,
  input  wire logic [19:0]                watch_page_i,
  input  wire logic                       mmio_enable_i,
  output gawu_pkg::job_t                  job_o
);
  localparam int unsigned RcW = $clog2(RANGE_ENTRIES + 1);
  localparam int unsigned VcW = $clog2(VALUE_ENTRIES + 1);
  localparam int unsigned RiW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
  localparam int unsigned ViW = (VALUE_ENTRIES > 1) ? $clog2(VALUE_ENTRIES) : 1;

  logic [31:0] starts_q [RANGE_ENTRIES];
  logic [31:0] ends_q   [RANGE_ENTRIES];
  logic [31:0] vals_q   [VALUE_ENTRIES];
  logic [RcW-1:0] rcnt_q;
  logic [VcW-1:0] vcnt_q;

  logic [31:0] addr, lo, hi, alast, a2, vlast;
  logic [32:0] sum;
  logic        ok, mmio, rdup;
  logic [2:0]  ahit;  // address, address+4, last address
  logic [2:0]  vhit;  // lo, hi, last value
  logic [2:0]  op;
  gawu_pkg::job_t j;

  assign op    = item_i.opcode;
  assign addr  = item_i.address;
  assign lo    = item_i.data[31:0];
  assign hi    = item_i.data[63:32];
  assign a2    = addr + 32'd4;
  assign alast = addr + item_i.size - 32'd4;
  assign vlast = (item_i.size == 32'd4) ? lo : item_i.last_word;
  assign sum   = {1'b0, addr} + {1'b0, item_i.size};

  // parallel compare against the watch page and all armed entries
  always_comb begin
    ahit = '0;
    vhit = '0;
    rdup = 1'b0;
    ahit[0] = (addr  & 32'hFFFFF000) == {watch_page_i, 12'h000};
    ahit[1] = (a2    & 32'hFFFFF000) == {watch_page_i, 12'h000};
    ahit[2] = (alast & 32'hFFFFF000) == {watch_page_i, 12'h000};
    for (int i = 0; i < RANGE_ENTRIES; i++) begin
      if (RcW'(i) < rcnt_q) begin
        if (addr  >= starts_q[i] && addr  < ends_q[i]) ahit[0] = 1'b1;
        if (a2    >= starts_q[i] && a2    < ends_q[i]) ahit[1] = 1'b1;
        if (alast >= starts_q[i] && alast < ends_q[i]) ahit[2] = 1'b1;
        if (starts_q[i] == addr) rdup = 1'b1;
      end
    end
    for (int i = 0; i < VALUE_ENTRIES; i++) begin
      if (VcW'(i) < vcnt_q) begin
        if (vals_q[i] == lo)    vhit[0] = 1'b1;
        if (vals_q[i] == hi)    vhit[1] = 1'b1;
        if (vals_q[i] == vlast) vhit[2] = 1'b1;
      end
    end
  end

  // range check against the guard limit, the 4 GiB space and the attached memory
  assign ok = (addr >= gawu_pkg::GuardLimit) && (item_i.size != 32'd0) &&
              (sum <= 33'h1_0000_0000) &&
              (mem_size_i != 33'd0) && ({1'b0, addr} < mem_size_i) &&
              (sum <= mem_size_i);
  assign mmio = mmio_enable_i && ((addr & gawu_pkg::MmioMask) == gawu_pkg::MmioBase);

  // classify
  always_comb begin
    j = '0;
    j.status = gawu_pkg::ST_OK;
    unique case (op) inside
      gawu_pkg::OP_ARM_RANGE: begin
        if (rdup) j.status = gawu_pkg::ST_DUP;
        else if (rcnt_q >= RcW'(RANGE_ENTRIES)) j.status = gawu_pkg::ST_FULL;
        else j.status = gawu_pkg::ST_ARMED;
      end
      gawu_pkg::OP_ARM_VALUE: begin
        if (vhit[0]) j.status = gawu_pkg::ST_DUP;
        else if (vcnt_q >= VcW'(VALUE_ENTRIES)) j.status = gawu_pkg::ST_FULL;
        else j.status = gawu_pkg::ST_ARMED;
      end
      gawu_pkg::OP_READ, gawu_pkg::OP_READ_NOW, gawu_pkg::OP_WRITE,
      gawu_pkg::OP_BULK: begin
        if ((op == gawu_pkg::OP_READ || op == gawu_pkg::OP_WRITE) &&
            item_i.size == 32'd4 && mmio) begin
          j.status = gawu_pkg::ST_MMIO;
        end else if (!ok) begin
          j.status = gawu_pkg::ST_INVALID;
        end else begin
          j.addr0 = addr;
          j.val0  = lo;
          if (op == gawu_pkg::OP_READ) begin
            j.hit = (item_i.size == 32'd4) && ahit[0];
          end else if (op == gawu_pkg::OP_WRITE) begin
            j.write = 1'b1;
            if (item_i.size == 32'd4) begin
              j.hit = ahit[0] || vhit[0];
            end else if (item_i.size == 32'd8) begin
              j.hit   = ahit[0] || ahit[1] || vhit[0] || vhit[1];
              j.two   = 1'b1;
              j.val0  = hi;
              j.addr1 = a2;
              j.val1  = lo;
            end
          end else if (op == gawu_pkg::OP_BULK) begin
            j.write = 1'b1;
            if (item_i.size >= 32'd4) begin
              j.hit   = ahit[0] || ahit[2] || vhit[0] || vhit[2];
              j.two   = item_i.size > 32'd4;
              j.addr1 = alast;
              j.val1  = vlast;
            end
          end
          if (!j.hit) begin
            j.two   = 1'b0;
            j.write = 1'b0;
          end
        end
      end
      default: j.status = gawu_pkg::ST_OK;
    endcase
  end
  assign job_o = j;

  // table counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0;
      vcnt_q <= '0;
    end else if (take_i && j.status == gawu_pkg::ST_ARMED) begin
      if (op == gawu_pkg::OP_ARM_RANGE) rcnt_q <= rcnt_q + RcW'(1);
      else vcnt_q <= vcnt_q + VcW'(1);
    end
  end

  // table entries
  always_ff @(posedge clk_i) begin
    if (take_i && j.status == gawu_pkg::ST_ARMED) begin
      if (op == gawu_pkg::OP_ARM_RANGE) begin
        starts_q[rcnt_q[RiW-1:0]] <= addr;
        ends_q[rcnt_q[RiW-1:0]]   <= item_i.range_end;
      end else begin
        vals_q[vcnt_q[ViW-1:0]] <= lo;
      end
    end
  end
endmodule
`default_nettype wire

[sv/gawu_queue.sv]
// gawu_queue: two-entry job queue between classifier and report stage
// depends on gawu_pkg
`default_nettype none
module gawu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire gawu_pkg::job_t job_i,
  output logic                full_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output gawu_pkg::job_t      job_o
);
  gawu_pkg::job_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end
endmodule
`default_nettype wire

[sv/gawu_back.sv]
// gawu_back: turns queued jobs into one or two result beats
// depends on gawu_pkg
`default_nettype none
module gawu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire gawu_pkg::job_t job_i,
  output logic                q_pop_o,
  output gawu_pkg::out_item_t res_o,
  output logic                empty_o,
  input  wire logic           pop_i
);
  logic second_q;
  logic beat;

  assign empty_o = q_empty_i;
  assign beat    = pop_i && !q_empty_i;
  assign q_pop_o = beat && (!job_i.two || second_q);

  // result beat
  always_comb begin
    res_o = '0;
    res_o.status = job_i.status;
    res_o.last   = !job_i.two || second_q;
    if (job_i.hit) begin
      res_o.report_valid   = 1'b1;
      res_o.report_write   = job_i.write;
      res_o.report_address = second_q ? job_i.addr1 : job_i.addr0;
      res_o.report_value   = second_q ? job_i.val1 : job_i.val0;
    end
  end

  // which half of a two-report job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) second_q <= 1'b0;
    else if (beat) second_q <= job_i.two && !second_q;
  end
endmodule
`default_nettype wire

[sv/guest_access_watchpoint_unit.sv]
// guest_access_watchpoint_unit: top level of the guest bus watchpoint unit
// depends on gawu_pkg, gawu_front, gawu_queue, gawu_back
//
//   channel  | handshake          | payload
//   input    | push / full        | in_item_i  (gawu_pkg::in_item_t)
//   result   | pop / empty        | out_item_o (gawu_pkg::out_item_t)
//   config   | cfg_we_i           | cfg_index_i, cfg_data_i
//
// an item is classified in the cycle it is taken, with all table entries
// compared in parallel; one item per cycle while the queue has room.
// its job is registered in the queue and read out in order; a two-report item gives two beats.
// reset empties the tables and queue; a stalled result side fills the
// two-entry queue and then raises full.
`default_nettype none
module guest_access_watchpoint_unit #(
  parameter int unsigned RANGE_ENTRIES = 64,
  parameter int unsigned VALUE_ENTRIES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire gawu_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output gawu_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [32:0]         cfg_data_i
);
  logic [32:0] mem_size_q;
  logic [19:0] watch_page_q;
  logic        mmio_enable_q;
  logic        take, q_empty, q_pop;
  gawu_pkg::job_t job_in, job_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q    <= '0;
      watch_page_q  <= gawu_pkg::WatchReset;
      mmio_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gawu_pkg::REG_MEM_SIZE:    mem_size_q    <= cfg_data_i;
        gawu_pkg::REG_WATCH_PAGE:  watch_page_q  <= cfg_data_i[19:0];
        gawu_pkg::REG_MMIO_ENABLE: mmio_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign take = push && !full;

  gawu_front #(
    .RANGE_ENTRIES(RANGE_ENTRIES),
    .VALUE_ENTRIES(VALUE_ENTRIES)
  ) u_front (
    .clk_i, .rst_ni,
    .take_i(take), .item_i(in_item_i),
    .mem_size_i(mem_size_q), .watch_page_i(watch_page_q),
    .mmio_enable_i(mmio_enable_q),
    .job_o(job_in)
  );

  gawu_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(take), .job_i(job_in), .full_o(full),
    .empty_o(q_empty), .pop_i(q_pop), .job_o(job_out)
  );

  gawu_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .job_i(job_out), .q_pop_o(q_pop),
    .res_o(out_item_o), .empty_o(empty), .pop_i(pop)
  );
endmodule
`default_nettype wire
